@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// The consequent holds at every edge at which the antecedent holds.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ hdl/u2u16_pkg.sv @@
// ---------------------------------------------------------------------------
// UTF-16 stream decoder package
// Shared types, codes and small helper functions of the decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package u2u16_pkg;

   localparam logic [1:0] FMT_UTF8  = 2'd0;
   localparam logic [1:0] FMT_UTF16 = 2'd1;
   localparam logic [1:0] FMT_UTF32 = 2'd2;

   localparam logic [1:0] CSR_TEXT_FORMAT = 2'd0;
   localparam logic [1:0] CSR_BIG_ENDIAN  = 2'd1;
   localparam logic [1:0] CSR_EXPECT_BOM  = 2'd2;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);
   localparam logic [QAW:0] QCOUNT_FULL = (QAW + 1)'(QDEPTH);

   typedef enum logic [1:0] {
      KIND_UNIT    = 2'd0,
      KIND_OK      = 2'd1,
      KIND_INVALID = 2'd2,
      KIND_TRUNC   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0,
      ERR_BOM  = 2'd1,
      ERR_BODY = 2'd2
   } err_type;

   typedef struct packed {
      logic [15:0] unit;
      kind_type    kind;
   } rslt_type;

   typedef struct packed {
      logic [1:0]         count;
      rslt_type [2:0]     res;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [7:0] bom_byte(input logic [1:0] fam, input logic be,
                                           input logic [1:0] idx);
      logic [7:0] r;
      r = 8'h00;
      if (fam == FMT_UTF16) begin
         if (be) r = idx[0] ? 8'hFF : 8'hFE;
         else    r = idx[0] ? 8'hFE : 8'hFF;
      end else if (fam == FMT_UTF32) begin
         unique case (idx)
            2'd0:    r = be ? 8'h00 : 8'hFF;
            2'd1:    r = be ? 8'h00 : 8'hFE;
            2'd2:    r = be ? 8'hFE : 8'h00;
            default: r = be ? 8'hFF : 8'h00;
         endcase
      end else begin
         unique case (idx)
            2'd0:    r = 8'hEF;
            2'd1:    r = 8'hBB;
            default: r = 8'hBF;
         endcase
      end
      return r;
   endfunction

   function automatic logic bad_value(input logic [31:0] cp);
      return (cp > 32'h0010_FFFF) || (cp >= 32'h0000_D800 && cp <= 32'h0000_DFFF);
   endfunction

   function automatic logic is_high_surr(input logic [15:0] u);
      return u[15:10] == 6'b110110;
   endfunction

   function automatic logic is_low_surr(input logic [15:0] u);
      return u[15:10] == 6'b110111;
   endfunction

endpackage

@@ hdl/u2u16_front.sv @@
// ---------------------------------------------------------------------------
// Decoder front end
// Holds the registers and the stream state, decodes one byte per request and
// pushes the group of results that the request causes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2u16_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [1:0]            csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   input  u2u16_pkg::qstat_type  q_stat,
   output logic                  push,
   output u2u16_pkg::entry_type  push_entry
);
   import u2u16_pkg::*;

   logic [1:0]  fmt_ff, fmt_in;
   logic        be_ff, be_in;
   logic        ebom_ff, ebom_in;

   logic [2:0]  bom_ff, bom_in;
   logic [1:0]  need_ff, need_in;
   logic [1:0]  seen_ff, seen_in;
   logic [20:0] acc_ff, acc_in;
   logic [1:0]  ocls_ff, ocls_in;
   logic        badc_ff, badc_in;
   logic [23:0] store_ff, store_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] held_ff, held_in;
   logic        hsw_ff, hsw_in;
   err_type     err_ff, err_in;

   logic        accept;
   logic [7:0]  b;
   logic [1:0]  fam;
   logic [2:0]  bom_len;
   logic        in_bom;
   logic [15:0] u0, u1;
   logic [1:0]  nu;
   logic        cp_req;
   logic [20:0] cp_val;
   logic [20:0] cp_off;
   logic [20:0] acc_v;
   logic        badc_v;
   logic [1:0]  seen_v;
   logic [20:0] min_v;
   logic [15:0] unit16;
   logic [31:0] cp32;
   kind_type    fin_kind;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;

   always_comb begin
      fam     = (fmt_ff == FMT_UTF16 || fmt_ff == FMT_UTF32) ? fmt_ff : FMT_UTF8;
      bom_len = (fam == FMT_UTF8) ? 3'd3 : ((fam == FMT_UTF16) ? 3'd2 : 3'd4);
      in_bom  = ebom_ff && (bom_ff < bom_len);
   end

   always_comb begin
      fmt_in  = fmt_ff;
      be_in   = be_ff;
      ebom_in = ebom_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TEXT_FORMAT: fmt_in  = csr_wdata;
            CSR_BIG_ENDIAN:  be_in   = csr_wdata[0];
            CSR_EXPECT_BOM:  ebom_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      bom_in   = bom_ff;
      need_in  = need_ff;
      seen_in  = seen_ff;
      acc_in   = acc_ff;
      ocls_in  = ocls_ff;
      badc_in  = badc_ff;
      store_in = store_ff;
      phase_in = phase_ff;
      held_in  = held_ff;
      hsw_in   = hsw_ff;
      err_in   = err_ff;
      u0       = 16'h0000;
      u1       = 16'h0000;
      nu       = 2'd0;
      cp_req   = 1'b0;
      cp_val   = 21'd0;
      cp_off   = 21'd0;
      acc_v    = acc_ff;
      badc_v   = badc_ff;
      seen_v   = seen_ff;
      min_v    = 21'h10000;
      unit16   = 16'h0000;
      cp32     = 32'd0;
      fin_kind = KIND_OK;
      push       = 1'b0;
      push_entry = '0;

      if (accept) begin
         if (req_tuser && err_ff != ERR_BOM) begin
            if (in_bom) begin
               if (b == bom_byte(fam, be_ff, bom_ff[1:0])) bom_in = bom_ff + 3'd1;
               else err_in = ERR_BOM;
            end else if (fam == FMT_UTF16) begin
               store_in = {store_ff[15:0], b};
               if (phase_ff == 2'd0) begin
                  phase_in = 2'd1;
               end else begin
                  unit16   = be_ff ? {store_ff[7:0], b} : {b, store_ff[7:0]};
                  phase_in = 2'd0;
                  if (err_ff == ERR_NONE) begin
                     if (hsw_ff) begin
                        hsw_in  = 1'b0;
                        held_in = 16'h0000;
                        if (is_low_surr(unit16)) begin
                           u0 = held_ff;
                           u1 = unit16;
                           nu = 2'd2;
                        end else begin
                           err_in = ERR_BODY;
                        end
                     end else if (is_high_surr(unit16)) begin
                        held_in = unit16;
                        hsw_in  = 1'b1;
                     end else if (is_low_surr(unit16)) begin
                        err_in = ERR_BODY;
                     end else begin
                        u0 = unit16;
                        nu = 2'd1;
                     end
                  end
               end
            end else if (fam == FMT_UTF32) begin
               if (phase_ff != 2'd3) begin
                  store_in = {store_ff[15:0], b};
                  phase_in = phase_ff + 2'd1;
               end else begin
                  cp32 = be_ff ? {store_ff[23:16], store_ff[15:8], store_ff[7:0], b}
                               : {b, store_ff[7:0], store_ff[15:8], store_ff[23:16]};
                  phase_in = 2'd0;
                  store_in = 24'd0;
                  if (err_ff == ERR_NONE) begin
                     if (bad_value(cp32)) begin
                        err_in = ERR_BODY;
                     end else begin
                        cp_req = 1'b1;
                        cp_val = cp32[20:0];
                     end
                  end
               end
            end else if (err_ff == ERR_NONE) begin
               if (need_ff == 2'd0) begin
                  if (!b[7]) begin
                     u0 = {8'h00, b};
                     nu = 2'd1;
                  end else if (b[7:5] == 3'b110) begin
                     acc_in  = {16'd0, b[4:0]};
                     need_in = 2'd1;
                     ocls_in = 2'd1;
                  end else if (b[7:4] == 4'b1110) begin
                     acc_in  = {17'd0, b[3:0]};
                     need_in = 2'd2;
                     ocls_in = 2'd2;
                  end else if (b[7:3] == 5'b11110) begin
                     acc_in  = {18'd0, b[2:0]};
                     need_in = 2'd3;
                     ocls_in = 2'd3;
                  end else begin
                     err_in = ERR_BODY;
                  end
                  seen_in = 2'd0;
                  badc_in = 1'b0;
               end else begin
                  if (b[7:6] != 2'b10) badc_v = 1'b1;
                  else acc_v = {acc_ff[14:0], b[5:0]};
                  seen_v = seen_ff + 2'd1;
                  if (seen_v >= need_ff) begin
                     min_v = (ocls_ff == 2'd1) ? 21'h80 :
                             ((ocls_ff == 2'd2) ? 21'h800 : 21'h10000);
                     if (badc_v || acc_v < min_v || bad_value({11'd0, acc_v})) begin
                        err_in = ERR_BODY;
                     end else begin
                        cp_req = 1'b1;
                        cp_val = acc_v;
                     end
                     need_in = 2'd0;
                     seen_in = 2'd0;
                     acc_in  = 21'd0;
                     ocls_in = 2'd0;
                     badc_in = 1'b0;
                  end else begin
                     seen_in = seen_v;
                     acc_in  = acc_v;
                     badc_in = badc_v;
                  end
               end
            end
         end

         if (cp_req) begin
            if (cp_val[20:16] == 5'd0) begin
               u0 = cp_val[15:0];
               nu = 2'd1;
            end else begin
               cp_off = cp_val - 21'h10000;
               u0 = {6'b110110, cp_off[19:10]};
               u1 = {6'b110111, cp_off[9:0]};
               nu = 2'd2;
            end
         end

         priority if (err_in == ERR_BOM || (ebom_ff && bom_in < bom_len))
            fin_kind = KIND_INVALID;
         else if (fam != FMT_UTF8 && phase_in != 2'd0)
            fin_kind = KIND_TRUNC;
         else if (err_in != ERR_NONE)
            fin_kind = KIND_INVALID;
         else if (fam == FMT_UTF8 && need_in != 2'd0)
            fin_kind = KIND_TRUNC;
         else if (fam == FMT_UTF16 && hsw_in)
            fin_kind = KIND_TRUNC;
         else
            fin_kind = KIND_OK;

         push_entry.res[0].unit = u0;
         push_entry.res[0].kind = KIND_UNIT;
         push_entry.res[1].unit = u1;
         push_entry.res[1].kind = KIND_UNIT;
         push_entry.count       = nu;
         if (req_tlast) begin
            push_entry.res[nu].unit = 16'h0000;
            push_entry.res[nu].kind = fin_kind;
            push_entry.count        = nu + 2'd1;
            bom_in   = 3'd0;
            need_in  = 2'd0;
            seen_in  = 2'd0;
            acc_in   = 21'd0;
            ocls_in  = 2'd0;
            badc_in  = 1'b0;
            store_in = 24'd0;
            phase_in = 2'd0;
            held_in  = 16'h0000;
            hsw_in   = 1'b0;
            err_in   = ERR_NONE;
         end
         push = (push_entry.count != 2'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= FMT_UTF8;
         be_ff    <= 1'b0;
         ebom_ff  <= 1'b0;
         bom_ff   <= 3'd0;
         need_ff  <= 2'd0;
         seen_ff  <= 2'd0;
         acc_ff   <= 21'd0;
         ocls_ff  <= 2'd0;
         badc_ff  <= 1'b0;
         store_ff <= 24'd0;
         phase_ff <= 2'd0;
         held_ff  <= 16'h0000;
         hsw_ff   <= 1'b0;
         err_ff   <= ERR_NONE;
      end else begin
         fmt_ff   <= fmt_in;
         be_ff    <= be_in;
         ebom_ff  <= ebom_in;
         bom_ff   <= bom_in;
         need_ff  <= need_in;
         seen_ff  <= seen_in;
         acc_ff   <= acc_in;
         ocls_ff  <= ocls_in;
         badc_ff  <= badc_in;
         store_ff <= store_in;
         phase_ff <= phase_in;
         held_ff  <= held_in;
         hsw_ff   <= hsw_in;
         err_ff   <= err_in;
      end
   end

endmodule

@@ hdl/u2u16_queue.sv @@
// ---------------------------------------------------------------------------
// Result group queue
// Short FIFO of result groups between the decoder front end and the output
// serializer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u2u16_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  u2u16_pkg::entry_type  push_entry,
   input  logic                  pop,
   output u2u16_pkg::entry_type  head,
   output u2u16_pkg::qstat_type  stat
);
   import u2u16_pkg::*;

   entry_type        mem_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]     count_ff, count_in;

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == QCOUNT_FULL);
   assign stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + (QAW + 1)'(1);
         2'b01:   count_in = count_ff - (QAW + 1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_IMPLY(a_q_no_overflow, push, !stat.full, "Queue pushed while full.")
   `ASSERT_IMPLY(a_q_no_underflow, pop, !stat.empty, "Queue popped while empty.")
   `ASSERT_ALWAYS(a_q_bound, count_ff <= QCOUNT_FULL, "Queue count beyond depth.")

endmodule

@@ hdl/u2u16_back.sv @@
// ---------------------------------------------------------------------------
// Output serializer
// Takes result groups from the queue and presents them one result at a time
// through a registered output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u2u16_back (
   input  logic                  clock,
   input  logic                  reset,
   input  u2u16_pkg::entry_type  head,
   input  u2u16_pkg::qstat_type  stat,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);
   import u2u16_pkg::*;

   logic [1:0]  idx_ff, idx_in;
   logic        vld_ff, vld_in;
   logic [15:0] unit_ff, unit_in;
   kind_type    kind_ff, kind_in;
   logic        last_ff, last_in;
   logic        load;
   logic        is_last;

   assign load    = !stat.empty && (!vld_ff || rsp_tready);
   assign is_last = (idx_ff == head.count - 2'd1);
   assign pop     = load && is_last;

   always_comb begin
      idx_in  = idx_ff;
      vld_in  = vld_ff;
      unit_in = unit_ff;
      kind_in = kind_ff;
      last_in = last_ff;
      if (load) begin
         vld_in  = 1'b1;
         unit_in = head.res[idx_ff].unit;
         kind_in = head.res[idx_ff].kind;
         last_in = is_last;
         idx_in  = is_last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = unit_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   `ASSERT_IMPLY(a_status_ends_run, rsp_tvalid && rsp_tuser != KIND_UNIT,
                 rsp_tlast && rsp_tdata == 16'h0000, "Status result not last or not zero.")
   `ASSERT_IMPLY(a_idx_has_group, idx_ff != 2'd0, !stat.empty,
                 "Partly sent group missing from queue.")

endmodule

@@ hdl/unicode_to_utf16_stream_decoder.sv @@
// ---------------------------------------------------------------------------
// UTF-8 / UTF-16 / UTF-32 to UTF-16 stream decoder
// Validating decoder that turns a byte stream into UTF-16 code units and ends
// each stream with a status result.
//
// Channel   Direction  Handshake                Payload
// req       in         req_tvalid / req_tready  tdata byte, tuser byte flag, tlast end
// rsp       out        rsp_tvalid / rsp_tready  tdata code unit, tuser kind, tlast last
// csr       in         csr_valid / csr_ready    csr_index, csr_wdata
//
// A request is decoded in the cycle it is accepted; one request per cycle is
// taken while the four-group result queue has room.
// Each request yields zero to three results, sent one per cycle while rsp_tready is
// high from a registered output stage, so sustained rate is one result per cycle.
// Output stalls fill the queue and then hold req_tready low.
// Reset is synchronous and clears registers and stream state; csr_ready is
// always high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module unicode_to_utf16_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] code_unit
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);
   import u2u16_pkg::*;

   qstat_type q_stat;
   entry_type push_entry;
   entry_type head;
   logic      push;
   logic      pop;

   u2u16_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   u2u16_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .stat       (q_stat)
   );

   u2u16_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .stat       (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
